// ----- design/assert_macros.svh -----
// Assertion macros for the PWM meter RTL.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge, quiet while reset is high.
`define PFDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, including reset.
`define PFDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/pfdm_pkg.sv -----
// Shared types and constants for the PWM frequency and duty meter.
// No dependencies.
`default_nettype none

package pfdm_pkg;

  localparam int unsigned STAMP_BITS_DEF = 32;
  localparam int unsigned JOBQ_DEPTH_DEF = 4;
  localparam int unsigned RESQ_DEPTH_DEF = 2;

  localparam int unsigned TPS_W   = 27;
  localparam int unsigned TMO_W   = 32;
  localparam int unsigned IDLE_W  = 32;
  localparam int unsigned FREQ_W  = 34;
  localparam int unsigned DUTY_W  = 10;
  localparam int unsigned WDATA_W = 32;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_TPS     = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

  localparam logic [TPS_W-1:0]  TPS_RESET  = 27'd1000000;
  localparam logic [TMO_W-1:0]  TMO_RESET  = 32'd1000000;
  localparam logic [DUTY_W-1:0] DUTY_FULL  = 10'd1000;
  localparam logic [IDLE_W-1:0] IDLE_MAX   = {IDLE_W{1'b1}};

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    logic              timed_out;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } bk_state_t;

endpackage

`default_nettype wire

// ----- design/pfdm_fifo.sv -----
// Small first-word-fall-through queue, used for jobs and for results.
// Depends on pfdm_pkg for the status struct.
`default_nettype none

module pfdm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = pfdm_pkg::JOBQ_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             rd,
  output logic      [WIDTH-1:0] rdata,
  output pfdm_pkg::qstat_t      stat
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_wr = wr && !stat.full;
  assign do_rd = rd && !stat.empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/pfdm_front.sv -----
// Front end: tick clock, edge detection, high time and timeout tracking.
// Emits one job word per result; depends on pfdm_pkg.
`default_nettype none

module pfdm_front #(
  parameter int unsigned STAMP_BITS = pfdm_pkg::STAMP_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          take,
  input  wire logic                          pin_level,
  input  wire logic [pfdm_pkg::TMO_W-1:0]    timeout_ticks,
  output logic                               job_push,
  output logic      [2*STAMP_BITS+1:0]       job_data
);

  logic [STAMP_BITS-1:0]           tick_clock;
  logic                            prev_level;
  logic [STAMP_BITS-1:0]           rise_stamp;
  logic [STAMP_BITS-1:0]           high_ticks;
  logic [pfdm_pkg::IDLE_W-1:0]     idle_ticks;
  logic                            in_timeout;

  logic [STAMP_BITS-1:0]           since_rise;
  logic [pfdm_pkg::IDLE_W-1:0]     idle_inc;
  logic                            rising;
  logic                            falling;
  logic                            measured;
  logic                            tmo_start;
  logic                            tmo_fall;

  assign since_rise = tick_clock - rise_stamp;
  assign rising     = pin_level && !prev_level;
  assign falling    = !pin_level && prev_level;
  assign measured   = rising && (since_rise != '0);
  assign idle_inc   = (idle_ticks == pfdm_pkg::IDLE_MAX) ? idle_ticks : idle_ticks + 1'b1;
  assign tmo_start  = !measured && !in_timeout && (idle_inc > timeout_ticks);
  assign tmo_fall   = !measured && in_timeout && falling;

  assign job_push = take && (measured || tmo_start || tmo_fall);
  // job word: measure flag, level, period, high time
  assign job_data = {measured, pin_level, since_rise, high_ticks};

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_clock <= '0;
      prev_level <= 1'b0;
      rise_stamp <= '0;
      high_ticks <= '0;
      idle_ticks <= '0;
      in_timeout <= 1'b0;
    end else if (take) begin
      tick_clock <= tick_clock + 1'b1;
      prev_level <= pin_level;
      if (rising) begin
        rise_stamp <= tick_clock;
      end else if (falling) begin
        high_ticks <= since_rise;
      end
      if (measured) begin
        idle_ticks <= '0;
        in_timeout <= 1'b0;
      end else begin
        idle_ticks <= idle_inc;
        if (tmo_start) begin
          in_timeout <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/pfdm_back.sv -----
// Back end: bit-serial dividers for frequency and duty, one job at a time.
// Depends on pfdm_pkg for the result struct and state type.
`default_nettype none

module pfdm_back #(
  parameter int unsigned STAMP_BITS = pfdm_pkg::STAMP_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [pfdm_pkg::TPS_W-1:0]    ticks_per_second,
  input  wire logic [2*STAMP_BITS+1:0]       job_data,
  input  wire pfdm_pkg::qstat_t              job_stat,
  output logic                               job_pop,
  input  wire pfdm_pkg::qstat_t              res_stat,
  output logic                               res_push,
  output pfdm_pkg::result_t                  res
);

  localparam int unsigned SB    = STAMP_BITS;
  localparam int unsigned FW    = pfdm_pkg::FREQ_W;
  localparam int unsigned DW    = pfdm_pkg::DUTY_W;
  localparam int unsigned NUM_W = SB + DW;
  localparam int unsigned CNT_W = $clog2(FW);

  pfdm_pkg::bk_state_t state;
  pfdm_pkg::bk_state_t state_next;

  logic            job_meas;
  logic            job_level;
  logic [SB-1:0]   job_period;
  logic [SB-1:0]   job_high;
  logic [NUM_W-1:0] high_x1000;
  logic [FW-1:0]   tps_x100;

  logic [CNT_W-1:0] cnt;
  logic [FW-1:0]    num;
  logic [SB-1:0]    rem;
  logic [FW-1:0]    quo;
  logic [SB-1:0]    dvs;
  logic [NUM_W-1:0] dsr;
  logic [NUM_W-1:0] dden;
  logic [DW-1:0]    dq;
  logic             clamp;

  logic [SB:0]      rem_sh;
  logic [SB:0]      rem_dif;
  logic             fbit;
  logic             dbit;
  logic             last;

  assign job_meas   = job_data[2*SB+1];
  assign job_level  = job_data[2*SB];
  assign job_period = job_data[2*SB-1:SB];
  assign job_high   = job_data[SB-1:0];

  // high*1000 = high*1024 - high*16 - high*8
  assign high_x1000 = {job_high, 10'b0} - {6'b0, job_high, 4'b0} - {7'b0, job_high, 3'b0};
  // tps*100 = tps*64 + tps*32 + tps*4
  assign tps_x100 = {1'b0, ticks_per_second, 6'b0} + {2'b0, ticks_per_second, 5'b0}
                  + {5'b0, ticks_per_second, 2'b0};

  assign rem_sh  = {rem, num[FW-1]};
  assign rem_dif = rem_sh - {1'b0, dvs};
  assign fbit    = (rem_sh >= {1'b0, dvs});
  assign dbit    = (dsr >= dden);
  assign last    = (cnt == CNT_W'(FW - 1));

  always_comb begin
    state_next = state;
    case (state)
      pfdm_pkg::BK_IDLE: begin
        if (!job_stat.empty) begin
          state_next = job_meas ? pfdm_pkg::BK_RUN : pfdm_pkg::BK_DONE;
        end
      end
      pfdm_pkg::BK_RUN: begin
        if (last) begin
          state_next = pfdm_pkg::BK_DONE;
        end
      end
      pfdm_pkg::BK_DONE: begin
        if (!res_stat.full) begin
          state_next = pfdm_pkg::BK_IDLE;
        end
      end
      default: state_next = pfdm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = 1'b0;
    res_push = 1'b0;
    case (state)
      pfdm_pkg::BK_IDLE: job_pop  = !job_stat.empty;
      pfdm_pkg::BK_DONE: res_push = !res_stat.full;
      default: begin
        job_pop  = 1'b0;
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfdm_pkg::BK_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (job_pop) begin
        cnt <= '0;
      end else if (state == pfdm_pkg::BK_RUN) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      if (job_meas) begin
        num   <= tps_x100;
        rem   <= '0;
        quo   <= '0;
        dvs   <= job_period;
        dsr   <= high_x1000;
        dden  <= {1'b0, job_period, 9'b0};
        dq    <= '0;
        clamp <= (job_high >= job_period);
      end else begin
        res.freq      <= '0;
        res.duty      <= job_level ? pfdm_pkg::DUTY_FULL : '0;
        res.timed_out <= 1'b1;
      end
    end else if (state == pfdm_pkg::BK_RUN) begin
      num <= {num[FW-2:0], 1'b0};
      rem <= fbit ? rem_dif[SB-1:0] : rem_sh[SB-1:0];
      quo <= {quo[FW-2:0], fbit};
      if (cnt < CNT_W'(DW)) begin
        if (dbit) begin
          dsr <= dsr - dden;
        end
        dq   <= {dq[DW-2:0], dbit};
        dden <= {1'b0, dden[NUM_W-1:1]};
      end
      if (last) begin
        res.freq      <= {quo[FW-2:0], fbit};
        res.duty      <= clamp ? pfdm_pkg::DUTY_FULL : dq;
        res.timed_out <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/pwm_frequency_duty_meter.sv -----
// PWM frequency and duty meter, top level.
// Usage: one word per tick on push/full carries pin_level. A rising edge
// with a nonzero period yields a word with freq_centihz (tick rate * 100 /
// period) and duty_tenths (high time * 1000 / period, clamped to 1000).
// After more than timeout_ticks ticks without a measurement a timed_out word
// reports freq 0 and the held level; while timed out, each falling edge
// reports again. Results leave on empty/pop, oldest first.
// Config: wr_en/wr_index/wr_data, index 0 ticks_per_second, 1 timeout_ticks;
// write only while idle.
// Path: measurement words go through the job queue and the 34-step serial
// divider in the back end; timeout words bypass the divider.
// Throughput: the front takes one tick per cycle while the 4-deep job queue
// has room; the back holds each job until its result is queued.
// Reset clears the tick clock, edge and timeout state and both queues;
// registers return to 1000000. If the receiver stalls, results queue up,
// then jobs, and full rises until pop drains them.
`default_nettype none
`include "assert_macros.svh"

module pwm_frequency_duty_meter #(
  parameter int unsigned STAMP_BITS = pfdm_pkg::STAMP_BITS_DEF,
  parameter int unsigned JOBQ_DEPTH = pfdm_pkg::JOBQ_DEPTH_DEF,
  parameter int unsigned RESQ_DEPTH = pfdm_pkg::RESQ_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              pin_level,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic      [pfdm_pkg::FREQ_W-1:0]       freq_centihz,
  output logic      [pfdm_pkg::DUTY_W-1:0]       duty_tenths,
  output logic                                   timed_out,
  input  wire logic                              wr_en,
  input  wire logic [pfdm_pkg::REG_IDX_W-1:0]    wr_index,
  input  wire logic [pfdm_pkg::WDATA_W-1:0]      wr_data
);

  localparam int unsigned JOB_W = 2 * STAMP_BITS + 2;
  localparam int unsigned RES_W = $bits(pfdm_pkg::result_t);

  logic [pfdm_pkg::TPS_W-1:0] ticks_per_second;
  logic [pfdm_pkg::TMO_W-1:0] timeout_ticks;

  logic              take;
  logic              job_push;
  logic [JOB_W-1:0]  job_in;
  logic [JOB_W-1:0]  job_out;
  logic              job_pop;
  pfdm_pkg::qstat_t  jobq_stat;
  logic              res_push;
  pfdm_pkg::result_t res_in;
  logic [RES_W-1:0]  res_out;
  pfdm_pkg::qstat_t  resq_stat;
  pfdm_pkg::result_t res_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= pfdm_pkg::TPS_RESET;
      timeout_ticks    <= pfdm_pkg::TMO_RESET;
    end else if (wr_en) begin
      case (wr_index)
        pfdm_pkg::REG_TPS:     ticks_per_second <= wr_data[pfdm_pkg::TPS_W-1:0];
        pfdm_pkg::REG_TIMEOUT: timeout_ticks    <= wr_data[pfdm_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  assign full = jobq_stat.full;
  assign take = push && !jobq_stat.full;

  pfdm_front #(
    .STAMP_BITS(STAMP_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .take(take),
    .pin_level(pin_level),
    .timeout_ticks(timeout_ticks),
    .job_push(job_push),
    .job_data(job_in)
  );

  pfdm_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(JOBQ_DEPTH)
  ) u_jobq (
    .clk(clk),
    .rst(rst),
    .wr(job_push),
    .wdata(job_in),
    .rd(job_pop),
    .rdata(job_out),
    .stat(jobq_stat)
  );

  pfdm_back #(
    .STAMP_BITS(STAMP_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .ticks_per_second(ticks_per_second),
    .job_data(job_out),
    .job_stat(jobq_stat),
    .job_pop(job_pop),
    .res_stat(resq_stat),
    .res_push(res_push),
    .res(res_in)
  );

  pfdm_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RESQ_DEPTH)
  ) u_resq (
    .clk(clk),
    .rst(rst),
    .wr(res_push),
    .wdata(res_in),
    .rd(pop),
    .rdata(res_out),
    .stat(resq_stat)
  );

  assign res_head     = pfdm_pkg::result_t'(res_out);
  assign empty        = resq_stat.empty;
  assign freq_centihz = res_head.freq;
  assign duty_tenths  = res_head.duty;
  assign timed_out    = res_head.timed_out;

  `PFDM_ASSERT(a_job_room, job_push |-> !jobq_stat.full, "job pushed into a full queue")
  `PFDM_ASSERT(a_res_room, res_push |-> !resq_stat.full, "result pushed into a full queue")
  `PFDM_ASSERT(a_tmo_freq, (res_push && res_in.timed_out) |-> (res_in.freq == '0), "timeout freq set")
  `PFDM_ASSERT(a_duty_max, !empty |-> (duty_tenths <= pfdm_pkg::DUTY_FULL), "duty above full scale")
  `PFDM_ASSERT_ALWAYS(a_rst_empty, rst |=> empty, "result queue not empty after reset")

endmodule

`default_nettype wire
